// ----- hw/rtl/cwts_pkg.sv -----
// ============================================================================
// cwts_pkg: shared types and constants for the coil winder traverse sequencer
// Holds the key codes, the key ladder thresholds, register indexes and the
// command and status structs that join the controller to the datapath.
// ============================================================================
package cwts_pkg;

  localparam int unsigned WIDTH_MAX = 63;
  localparam int unsigned TURNS_MAX = 255;

  // Key ladder thresholds on the 10-bit ADC sample.
  localparam logic [9:0] LEVEL_NONE_ABOVE   = 10'd1000;
  localparam logic [9:0] LEVEL_RIGHT_BELOW  = 10'd50;
  localparam logic [9:0] LEVEL_UP_BELOW     = 10'd195;
  localparam logic [9:0] LEVEL_DOWN_BELOW   = 10'd380;
  localparam logic [9:0] LEVEL_LEFT_BELOW   = 10'd555;
  localparam logic [9:0] LEVEL_SELECT_BELOW = 10'd790;

  // Register reset values.
  localparam logic [15:0] STEPS_PER_REV_RESET   = 16'd6400;
  localparam logic [5:0]  WIDTH_INCREMENT_RESET = 6'd1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_STEPS_PER_REV   = 1'b0,
    CFG_WIDTH_INCREMENT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    KEY_RIGHT  = 3'd0,
    KEY_UP     = 3'd1,
    KEY_DOWN   = 3'd2,
    KEY_LEFT   = 3'd3,
    KEY_SELECT = 3'd4,
    KEY_NONE   = 3'd5
  } key_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic take;   // load a new pass into the datapath
    logic emit;   // move the current beat into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic final_beat;  // the current beat is the last of the pass
  } dp_status_t;

  function automatic key_t decode_key(input logic [9:0] level);
    key_t k;
    begin
      if (level > LEVEL_NONE_ABOVE) begin
        k = KEY_NONE;
      end else if (level < LEVEL_RIGHT_BELOW) begin
        k = KEY_RIGHT;
      end else if (level < LEVEL_UP_BELOW) begin
        k = KEY_UP;
      end else if (level < LEVEL_DOWN_BELOW) begin
        k = KEY_DOWN;
      end else if (level < LEVEL_LEFT_BELOW) begin
        k = KEY_LEFT;
      end else if (level < LEVEL_SELECT_BELOW) begin
        k = KEY_SELECT;
      end else begin
        k = KEY_NONE;
      end
      return k;
    end
  endfunction

endpackage

// ----- hw/rtl/cwts_ctrl.sv -----
// ============================================================================
// cwts_ctrl: pass controller
// Takes one pass at a time, then walks its beats into the output register.
// ============================================================================
module cwts_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  cwts_pkg::dp_status_t   status,
  output cwts_pkg::ctrl_cmd_t    cmd
);

  cwts_pkg::ctrl_state_t state;
  cwts_pkg::ctrl_state_t state_next;
  logic                  out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      cwts_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = cwts_pkg::ST_EMIT;
        end
      end
      cwts_pkg::ST_EMIT: begin
        if (cmd.emit && status.final_beat) begin
          state_next = cwts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cwts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.take = 1'b0;
    cmd.emit = 1'b0;
    case (state)
      cwts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      cwts_pkg::ST_EMIT: begin
        cmd.emit = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cwts_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/cwts_dp.sv -----
// ============================================================================
// cwts_dp: sequencer datapath
// Key handling, winding counters, beat counter and the output register.
// ============================================================================
module cwts_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [9:0]            key_level,
  input  logic                  endstop,
  input  cwts_pkg::ctrl_cmd_t   cmd,
  output cwts_pkg::dp_status_t  status,
  output logic                  spindle_step,
  output logic                  traverse_move,
  output logic                  traverse_dir,
  output logic                  running,
  output logic [7:0]            turns_setting,
  output logic [5:0]            width_setting,
  output logic                  last
);

  // Configuration registers.
  logic [15:0] steps_per_rev;
  logic [5:0]  width_increment;

  // Winding state.
  cwts_pkg::key_t previous_key;
  logic        winding_on;
  logic [7:0]  turns_per_traverse;
  logic [5:0]  traverse_width;
  logic [7:0]  revolution_count;
  logic [15:0] spindle_step_count;
  logic        heading_left;
  logic [15:0] left_move_count;

  // Per-pass beat descriptor.
  logic [5:0]  beat;
  logic [5:0]  beat_final;
  logic        pass_step;
  logic        pass_move;
  logic        pass_dir;

  cwts_pkg::key_t key_now;
  logic        winding_on_next;
  logic [7:0]  turns_per_traverse_next;
  logic [5:0]  traverse_width_next;
  logic [7:0]  revolution_count_next;
  logic [15:0] spindle_step_count_next;
  logic        heading_left_next;
  logic [15:0] left_move_count_next;
  logic [5:0]  beat_final_next;
  logic        pass_step_next;
  logic        pass_move_next;
  logic        pass_dir_next;
  logic [6:0]  width_sum;
  logic [16:0] step_count_inc;

  always_comb begin
    key_now                 = cwts_pkg::decode_key(key_level);
    winding_on_next         = winding_on;
    turns_per_traverse_next = turns_per_traverse;
    traverse_width_next     = traverse_width;
    revolution_count_next   = revolution_count;
    spindle_step_count_next = spindle_step_count;
    heading_left_next       = heading_left;
    left_move_count_next    = left_move_count;
    beat_final_next         = 6'd0;
    pass_step_next          = 1'b0;
    pass_move_next          = 1'b0;
    pass_dir_next           = 1'b0;
    width_sum               = {1'b0, traverse_width} + {1'b0, width_increment};
    step_count_inc          = {1'b0, spindle_step_count} + 17'd1;

    // Keys act only on a change of the decoded code.
    if (key_now != previous_key) begin
      case (key_now)
        cwts_pkg::KEY_RIGHT: begin
          if (width_sum > 7'(cwts_pkg::WIDTH_MAX)) begin
            traverse_width_next = 6'(cwts_pkg::WIDTH_MAX);
          end else begin
            traverse_width_next = width_sum[5:0];
          end
        end
        cwts_pkg::KEY_LEFT: begin
          if (traverse_width > 6'd1) begin
            if (width_increment >= traverse_width) begin
              traverse_width_next = 6'd0;
            end else begin
              traverse_width_next = traverse_width - width_increment;
            end
          end
        end
        cwts_pkg::KEY_UP: begin
          if (turns_per_traverse < 8'(cwts_pkg::TURNS_MAX)) begin
            turns_per_traverse_next = turns_per_traverse + 8'd1;
          end
        end
        cwts_pkg::KEY_DOWN: begin
          if (turns_per_traverse > 8'd1) begin
            turns_per_traverse_next = turns_per_traverse - 8'd1;
          end
        end
        cwts_pkg::KEY_SELECT: begin
          winding_on_next = !winding_on;
        end
        default: begin
          winding_on_next = winding_on;
        end
      endcase
    end

    if (winding_on_next) begin
      pass_step_next = 1'b1;
      if (revolution_count < turns_per_traverse_next) begin
        // Single spindle step; the count is widened to 17 bits and returns to zero at steps_per_rev.
        if (step_count_inc >= {1'b0, steps_per_rev}) begin
          spindle_step_count_next = 16'd0;
          if (revolution_count != 8'hFF) begin
            revolution_count_next = revolution_count + 8'd1;
          end
        end else begin
          spindle_step_count_next = step_count_inc[15:0];
        end
      end else begin
        // Traverse pass: endstop and direction first, then width+1 beats.
        pass_move_next  = 1'b1;
        beat_final_next = traverse_width_next;
        if (!endstop) begin
          heading_left_next = 1'b0;
        end else if (heading_left && (left_move_count != 16'hFFFF)) begin
          left_move_count_next = left_move_count + 16'd1;
        end
        pass_dir_next = !heading_left_next && (left_move_count_next != 16'd0);
        if (pass_dir_next) begin
          left_move_count_next = left_move_count_next - 16'd1;
        end
        if (!heading_left_next && (left_move_count_next == 16'd0)) begin
          heading_left_next = 1'b1;
        end
        revolution_count_next = 8'd0;
      end
    end
  end

  assign status.final_beat = (beat == beat_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev   <= cwts_pkg::STEPS_PER_REV_RESET;
      width_increment <= cwts_pkg::WIDTH_INCREMENT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cwts_pkg::CFG_STEPS_PER_REV:   steps_per_rev   <= cfg_data;
        cwts_pkg::CFG_WIDTH_INCREMENT: width_increment <= cfg_data[5:0];
        default:                       steps_per_rev   <= steps_per_rev;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_key       <= cwts_pkg::KEY_RIGHT;
      winding_on         <= 1'b0;
      turns_per_traverse <= 8'd1;
      traverse_width     <= 6'd4;
      revolution_count   <= 8'd0;
      spindle_step_count <= 16'd0;
      heading_left       <= 1'b1;
      left_move_count    <= 16'd0;
      beat               <= 6'd0;
      beat_final         <= 6'd0;
      pass_step          <= 1'b0;
      pass_move          <= 1'b0;
      pass_dir           <= 1'b0;
    end else if (cmd.take) begin
      previous_key       <= key_now;
      winding_on         <= winding_on_next;
      turns_per_traverse <= turns_per_traverse_next;
      traverse_width     <= traverse_width_next;
      revolution_count   <= revolution_count_next;
      spindle_step_count <= spindle_step_count_next;
      heading_left       <= heading_left_next;
      left_move_count    <= left_move_count_next;
      beat               <= 6'd0;
      beat_final         <= beat_final_next;
      pass_step          <= pass_step_next;
      pass_move          <= pass_move_next;
      pass_dir           <= pass_dir_next;
    end else if (cmd.emit) begin
      beat <= beat + 6'd1;
    end
  end

  // Output register; settings hold steady while a pass is being emitted.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      spindle_step  <= pass_step;
      traverse_move <= pass_move;
      traverse_dir  <= pass_dir;
      running       <= winding_on;
      turns_setting <= turns_per_traverse;
      width_setting <= traverse_width;
      last          <= status.final_beat;
    end
  end

endmodule

// ----- hw/rtl/coil_winder_traverse_sequencer_top.sv -----
// ============================================================================
// coil_winder_traverse_sequencer_top: traverse sequencer for a coil winder
// Decodes the key ladder, keeps the winding settings and counters, and
// issues the spindle step and traverse move beats of each control pass.
// ============================================================================
// Usage:
// Each input beat (in_valid/in_ready) is one control pass carrying the key
// ladder ADC sample and the endstop level. Each output beat
// (out_valid/out_ready) is one result: a spindle step flag, a traverse move
// flag with its direction, the current settings, and last on the final beat
// of the pass. An idle or single-step pass gives one beat; a traverse pass
// gives width_setting+1 beats, at most 64.
// The block works on one pass at a time. A pass is taken into the datapath;
// once the controller enters its emit state and the output register is free,
// the first result is loaded, and then one beat is issued per cycle while
// the receiver keeps out_ready high. The beat counter walks the results
// through the single output register. in_ready is high again as soon as the
// last beat is loaded, even if it is still waiting to be taken.
// When the receiver stalls, the output beat holds and the sequencer waits.
// Synchronous active-high reset restores the power-up settings (width 4,
// one turn per traverse, 6400 steps per revolution, winding off) and
// empties the output register. Configuration writes take effect at once
// and should only be made while the block is idle.
module coil_winder_traverse_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  key_level,
  input  logic        endstop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        spindle_step,
  output logic        traverse_move,
  output logic        traverse_dir,
  output logic        running,
  output logic [7:0]  turns_setting,
  output logic [5:0]  width_setting,
  output logic        last
);

  cwts_pkg::ctrl_cmd_t  cmd;
  cwts_pkg::dp_status_t status;

  // The controller sequences passes and beats.
  cwts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the settings, counters and output register.
  cwts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .key_level     (key_level),
    .endstop       (endstop),
    .cmd           (cmd),
    .status        (status),
    .spindle_step  (spindle_step),
    .traverse_move (traverse_move),
    .traverse_dir  (traverse_dir),
    .running       (running),
    .turns_setting (turns_setting),
    .width_setting (width_setting),
    .last          (last)
  );

`ifndef ASSERT_OFF
  // Only one pass is in flight: taking one closes the input.
  a_one_pass: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a pass is in flight");

  // An idle status result is a single beat with no step.
  a_idle_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running |-> last && !spindle_step && !traverse_move)
    else $error("idle pass gave a step or more than one beat");

  // The direction flag is only set on traverse moves.
  a_dir_on_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && !traverse_move |-> !traverse_dir)
    else $error("direction set without a traverse move");

  // Every traverse move is paired with a spindle step.
  a_move_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && traverse_move |-> spindle_step)
    else $error("traverse move without a spindle step");
`endif

endmodule
